/* design/bawn_pkg.sv */
// Shared types and constants for the backward affine warp core.
// No dependencies; imported by the top level, controller, datapath and checker.
`timescale 1ns / 1ps

package bawn_pkg;

    // Geometry and fixed-point format
    localparam int MAX_ROWS   = 256;
    localparam int MAX_COLS   = 256;
    localparam int FRAC_BITS  = 16;

    // Field widths fixed by the interface
    localparam int PIX_W      = 8;
    localparam int COORD_W    = 8;
    localparam int DIM_W      = 9;
    localparam int COEF_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Frame store
    localparam int DEPTH      = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int RIDX_W     = $clog2(MAX_ROWS);
    localparam int CIDX_W     = $clog2(MAX_COLS);

    // Arithmetic widths: unsigned coord (as signed) times signed coefficient,
    // then a three-term sum, then the fraction dropped.
    localparam int PROD_W     = COORD_W + 1 + COEF_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int Q_W        = SUM_W - FRAC_BITS;
    localparam int CMP_W      = 14;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_ROWS        = 3'd0,
        REG_FRAME_COLS        = 3'd1,
        REG_COEF_ROW_FROM_ROW = 3'd2,
        REG_COEF_COL_FROM_ROW = 3'd3,
        REG_COEF_ROW_FROM_COL = 3'd4,
        REG_COEF_COL_FROM_COL = 3'd5,
        REG_OFFSET_ROW        = 3'd6,
        REG_OFFSET_COL        = 3'd7
    } cfg_idx_t;

    // Controller to datapath
    typedef struct packed {
        logic load_wr;
        logic capture;
        logic mul_en;
        logic sum_en;
        logic addr_en;
        logic rd_en;
        logic out_load;
    } bawn_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_stall;
    } bawn_sts_t;

endpackage

/* design/bawn_if.sv */
// Request and result channel interfaces (valid/ready plus payload).
// Widths are fixed by the block's field list; no package dependency.
`timescale 1ns / 1ps

interface bawn_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] pixel_in;

    modport source (output valid, output mode, output row, output col,
                    output pixel_in, input ready);
    modport sink   (input valid, input mode, input row, input col,
                    input pixel_in, output ready);
endinterface

interface bawn_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_out;
    logic       inside_res;

    modport source (output valid, output pixel_out, output inside_res, input ready);
    modport sink   (input valid, input pixel_out, input inside_res, output ready);
endinterface

/* design/backward_affine_warp_nearest_core.sv */
// Top level of the backward affine warp core: controller plus datapath.
// Depends on bawn_pkg, bawn_if, bawn_ctrl and bawn_dp.
`timescale 1ns / 1ps

// Backward affine warp, nearest-neighbor sampling. Requests on in_ch are
// either loads (mode 0: write pixel_in to the 256x256 frame store at
// row,col on the accepting edge; no result) or fetches (mode 1: map output
// row,col through the inverse matrix in Q15.16, truncate toward zero and
// return the stored pixel with inside_res=1, or pixel 0 with inside_res=0
// when the source point falls outside frame_rows x frame_cols). A fetch
// holds in_ch.ready low from its accepting edge until its result is
// loaded, so no new request is taken while a fetch is in flight. Its steps
// are four 9x32 multiplies, the two three-term sums, truncation, bounds
// check and address, the registered frame-store read, and loading the
// result register. The result register sits between the block and
// out_ch, so a new request is taken while a result waits; a fetch that
// finishes while the previous result is still unclaimed waits in its last
// step. The frame store has no reset and no clearing pass: every pixel a
// fetch can reach must be loaded first. Config writes
// (cfg_we/cfg_index/cfg_wdata) are legal only while no request is in
// flight; unknown indexes are ignored.
module backward_affine_warp_nearest_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bawn_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bawn_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    bawn_in_if.sink                             in_ch,
    bawn_out_if.source                          out_ch
);
    import bawn_pkg::*;

    bawn_cmd_t cmd;
    bawn_sts_t sts;
    logic      in_ready;

    bawn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_mode  (in_ch.mode),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bawn_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .row       (in_ch.row),
        .col       (in_ch.col),
        .pixel_in  (in_ch.pixel_in),
        .cmd       (cmd),
        .sts       (sts),
        .res_ch    (out_ch)
    );

    // Ready only in the idle step; loads complete on the accepting edge
    assign in_ch.ready = in_ready;

endmodule

/* design/bawn_ctrl.sv */
// Sequencing state machine for the warp core.
// Depends on bawn_pkg for the command and status structs.
`timescale 1ns / 1ps

module bawn_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_mode,
    output logic                in_ready,
    input  bawn_pkg::bawn_sts_t sts,
    output bawn_pkg::bawn_cmd_t cmd
);
    import bawn_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_SUM  = 6'b000100,
        S_ADDR = 6'b001000,
        S_READ = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd          = '0;
        cmd.load_wr  = accept && (in_mode == MODE_LOAD);
        cmd.capture  = accept && (in_mode == MODE_FETCH);
        cmd.mul_en   = (state_reg == S_MUL);
        cmd.sum_en   = (state_reg == S_SUM);
        cmd.addr_en  = (state_reg == S_ADDR);
        cmd.rd_en    = (state_reg == S_READ);
        cmd.out_load = (state_reg == S_OUT) && !sts.out_stall;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (cmd.capture) state_next = S_MUL;
            S_MUL:  state_next = S_SUM;
            S_SUM:  state_next = S_ADDR;
            S_ADDR: state_next = S_READ;
            S_READ: state_next = S_OUT;
            S_OUT:  if (!sts.out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* design/bawn_dp.sv */
// Datapath: config registers, coordinate mapping, frame store, result register.
// Depends on bawn_pkg and the bawn_out_if interface.
`timescale 1ns / 1ps

module bawn_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [bawn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bawn_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [bawn_pkg::COORD_W-1:0]         row,
    input  logic [bawn_pkg::COORD_W-1:0]         col,
    input  logic [bawn_pkg::PIX_W-1:0]           pixel_in,
    input  bawn_pkg::bawn_cmd_t                  cmd,
    output bawn_pkg::bawn_sts_t                  sts,
    bawn_out_if.source                           res_ch
);
    import bawn_pkg::*;

    // Configuration
    logic [DIM_W-1:0]         frame_rows_reg;
    logic [DIM_W-1:0]         frame_cols_reg;
    logic signed [COEF_W-1:0] c_rr_reg;
    logic signed [COEF_W-1:0] c_cr_reg;
    logic signed [COEF_W-1:0] c_rc_reg;
    logic signed [COEF_W-1:0] c_cc_reg;
    logic signed [COEF_W-1:0] off_r_reg;
    logic signed [COEF_W-1:0] off_c_reg;

    // Fetch pipeline
    logic [COORD_W-1:0]       frow_reg;
    logic [COORD_W-1:0]       fcol_reg;
    logic signed [COORD_W:0]  frow_s;
    logic signed [COORD_W:0]  fcol_s;
    logic signed [PROD_W-1:0] p_rr_reg;
    logic signed [PROD_W-1:0] p_cr_reg;
    logic signed [PROD_W-1:0] p_rc_reg;
    logic signed [PROD_W-1:0] p_cc_reg;
    logic signed [SUM_W-1:0]  sum_r_reg;
    logic signed [SUM_W-1:0]  sum_c_reg;
    logic [SUM_W-1:0]         tr_r;
    logic [SUM_W-1:0]         tr_c;
    logic [Q_W-1:0]           q_r;
    logic [Q_W-1:0]           q_c;
    logic                     in_r;
    logic                     in_c;
    logic [ADDR_W-1:0]        rd_addr_next;
    logic [ADDR_W-1:0]        rd_addr_reg;
    logic                     inside_reg;
    logic [PIX_W-1:0]         rd_data_reg;

    // Load path
    logic                     ld_ok;
    logic [ADDR_W-1:0]        wr_addr;

    // Result register
    logic                     out_valid_reg;
    logic [PIX_W-1:0]         out_pix_reg;
    logic                     out_inside_reg;

    logic [PIX_W-1:0]         frame_mem [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_rows_reg <= DIM_W'(MAX_ROWS);
            frame_cols_reg <= DIM_W'(MAX_COLS);
            c_rr_reg       <= COEF_W'(1 << FRAC_BITS);
            c_cr_reg       <= '0;
            c_rc_reg       <= '0;
            c_cc_reg       <= COEF_W'(1 << FRAC_BITS);
            off_r_reg      <= '0;
            off_c_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_ROWS:        frame_rows_reg <= cfg_wdata[DIM_W-1:0];
                REG_FRAME_COLS:        frame_cols_reg <= cfg_wdata[DIM_W-1:0];
                REG_COEF_ROW_FROM_ROW: c_rr_reg       <= cfg_wdata;
                REG_COEF_COL_FROM_ROW: c_cr_reg       <= cfg_wdata;
                REG_COEF_ROW_FROM_COL: c_rc_reg       <= cfg_wdata;
                REG_COEF_COL_FROM_COL: c_cc_reg       <= cfg_wdata;
                REG_OFFSET_ROW:        off_r_reg      <= cfg_wdata;
                REG_OFFSET_COL:        off_c_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Loads beyond the store are dropped
    assign ld_ok   = (CMP_W'(row) < CMP_W'(MAX_ROWS)) && (CMP_W'(col) < CMP_W'(MAX_COLS));
    assign wr_addr = ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col);

    assign frow_s = $signed({1'b0, frow_reg});
    assign fcol_s = $signed({1'b0, fcol_reg});

    // Truncate toward zero: bias negatives by 2^F - 1 before the arithmetic shift
    assign tr_r = sum_r_reg + (sum_r_reg[SUM_W-1] ? SUM_W'((1 << FRAC_BITS) - 1) : '0);
    assign tr_c = sum_c_reg + (sum_c_reg[SUM_W-1] ? SUM_W'((1 << FRAC_BITS) - 1) : '0);
    assign q_r  = tr_r[SUM_W-1:FRAC_BITS];
    assign q_c  = tr_c[SUM_W-1:FRAC_BITS];

    assign in_r = !q_r[Q_W-1] && (q_r < Q_W'(frame_rows_reg)) && (q_r < Q_W'(MAX_ROWS));
    assign in_c = !q_c[Q_W-1] && (q_c < Q_W'(frame_cols_reg)) && (q_c < Q_W'(MAX_COLS));

    assign rd_addr_next = ADDR_W'(q_r[RIDX_W-1:0]) * ADDR_W'(MAX_COLS)
                        + ADDR_W'(q_c[CIDX_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            frow_reg <= row;
            fcol_reg <= col;
        end
        if (cmd.mul_en)
        begin
            p_rr_reg <= frow_s * c_rr_reg;
            p_rc_reg <= fcol_s * c_rc_reg;
            p_cr_reg <= frow_s * c_cr_reg;
            p_cc_reg <= fcol_s * c_cc_reg;
        end
        if (cmd.sum_en)
        begin
            sum_r_reg <= SUM_W'(p_rr_reg) + SUM_W'(p_rc_reg) + SUM_W'(off_r_reg);
            sum_c_reg <= SUM_W'(p_cr_reg) + SUM_W'(p_cc_reg) + SUM_W'(off_c_reg);
        end
        if (cmd.addr_en)
        begin
            rd_addr_reg <= rd_addr_next;
            inside_reg  <= in_r && in_c;
        end
    end

    // Frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && ld_ok)
            frame_mem[wr_addr] <= pixel_in;
        if (cmd.rd_en)
            rd_data_reg <= frame_mem[rd_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (res_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_pix_reg    <= inside_reg ? rd_data_reg : '0;
            out_inside_reg <= inside_reg;
        end
    end

    assign sts.out_stall     = out_valid_reg && !res_ch.ready;
    assign res_ch.valid      = out_valid_reg;
    assign res_ch.pixel_out  = out_pix_reg;
    assign res_ch.inside_res = out_inside_reg;

endmodule

/* design/bawn_checker.sv */
// Port-level checks for the warp core, bound to the top level.
// Depends on bawn_pkg for the mode encoding.
`timescale 1ns / 1ps

module bawn_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_mode,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] pixel_out,
    input logic       inside_res
);
    import bawn_pkg::*;

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(inside_res))
        else $error("result changed while stalled");

    // Outside the frame the pixel is zero
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !inside_res |-> pixel_out == '0)
        else $error("nonzero pixel outside frame");

    // A load leaves the request port ready
    a_load_one: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_mode == MODE_LOAD) |=> in_ready)
        else $error("load did not free the request port");

    // A fetch occupies the block
    a_fetch_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_mode == MODE_FETCH) |=> !in_ready)
        else $error("request taken during fetch");

endmodule

bind backward_affine_warp_nearest_core bawn_checker u_bawn_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_mode    (in_ch.mode),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .pixel_out  (out_ch.pixel_out),
    .inside_res (out_ch.inside_res)
);
